@@ sv/c8_pkg.sv @@
`default_nettype none
package c8_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int PROGRAM_START_DEF = 512;

  localparam int SCR_ROWS = 32;
  localparam int SCR_W = 64;
  localparam int SCR_RW = $clog2(SCR_ROWS);

  localparam int FONT_LEN = 80;
  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [2:0] {
    OP_EXEC, OP_WRMEM, OP_RDMEM, OP_RDPIX, OP_SETDLY, OP_SETSND, OP_START, OP_STOP
  } op_t;

  typedef enum logic [3:0] {
    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL
  } alu_fn_t;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;
  localparam logic [7:0] KK_SKP = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_LDDT = 8'h07;
  localparam logic [7:0] KK_WAITK = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD = 8'h65;

endpackage
`default_nettype wire

@@ sv/c8_if.sv @@
`default_nettype none
interface c8_req_if;
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [11:0] addr;
  logic [7:0] data;
  logic [15:0] keys_held;
  logic [7:0] random_byte;
  modport source(output valid, op, addr, data, keys_held, random_byte, input ready);
  modport sink(input valid, op, addr, data, keys_held, random_byte, output ready);
endinterface

interface c8_rsp_if;
  logic valid;
  logic ready;
  logic [11:0] pc_out;
  logic [15:0] index_out;
  logic [7:0] flag_out;
  logic [7:0] read_data;
  logic [7:0] delay_out;
  logic [7:0] sound_out;
  logic stopped;
  logic waiting_key;
  modport source(output valid, pc_out, index_out, flag_out, read_data, delay_out,
                 sound_out, stopped, waiting_key, input ready);
  modport sink(input valid, pc_out, index_out, flag_out, read_data, delay_out,
               sound_out, stopped, waiting_key, output ready);
endinterface
`default_nettype wire

@@ sv/c8_mem.sv @@
`default_nettype none
module c8_mem #(
  parameter int MEM_BYTES = c8_pkg::MEM_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  output logic                              ready,
  input  wire logic                         we,
  input  wire logic [$clog2(MEM_BYTES)-1:0] addr,
  input  wire logic [7:0]                   wdata,
  output logic [7:0]                        rdata
);
  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0] mem [MEM_BYTES];
  logic [AW-1:0] clr_addr;
  logic [7:0] clr_data;

  always_comb begin
    clr_data = 8'h00;
    if (clr_addr < AW'(c8_pkg::FONT_LEN)) begin
      clr_data = c8_pkg::FONT[clr_addr[6:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
      clr_addr <= '0;
    end else if (!ready) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MEM_BYTES - 1)) begin
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_addr] <= clr_data;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ sv/c8_screen.sv @@
`default_nettype none
module c8_screen (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      clr,
  output logic                           busy,
  input  wire logic                      we,
  input  wire logic [c8_pkg::SCR_RW-1:0] row,
  input  wire logic [c8_pkg::SCR_W-1:0]  wdata,
  output logic [c8_pkg::SCR_W-1:0]       rdata
);
  logic [c8_pkg::SCR_W-1:0] rows [c8_pkg::SCR_ROWS];
  logic [c8_pkg::SCR_RW-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + c8_pkg::SCR_RW'(1);
      if (clr_row == c8_pkg::SCR_RW'(c8_pkg::SCR_ROWS - 1)) begin
        busy <= 1'b0;
      end
    end else if (clr) begin
      busy <= 1'b1;
      clr_row <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rows[clr_row] <= '0;
    end else if (we) begin
      rows[row] <= wdata;
    end
    rdata <= rows[row];
  end
endmodule
`default_nettype wire

@@ sv/c8_alu.sv @@
`default_nettype none
module c8_alu (
  input  wire c8_pkg::alu_fn_t fn,
  input  wire logic [7:0]      a,
  input  wire logic [7:0]      b,
  output logic [7:0]           res,
  output logic                 flag
);
  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    res = b;
    flag = 1'b0;
    unique case (fn)
      c8_pkg::ALU_MOV: res = b;
      c8_pkg::ALU_OR: res = a | b;
      c8_pkg::ALU_AND: res = a & b;
      c8_pkg::ALU_XOR: res = a ^ b;
      c8_pkg::ALU_ADD: begin
        res = sum[7:0];
        flag = sum[8];
      end
      c8_pkg::ALU_SUB: begin
        res = a - b;
        flag = (a >= b);
      end
      c8_pkg::ALU_SHR: begin
        res = {1'b0, a[7:1]};
        flag = a[0];
      end
      c8_pkg::ALU_SUBN: begin
        res = b - a;
        flag = (b >= a);
      end
      c8_pkg::ALU_SHL: begin
        res = {a[6:0], 1'b0};
        flag = a[7];
      end
      default: res = b;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/chip8_instruction_core.sv @@
// CHIP-8 instruction core with host access to its memory, screen and timers.
// Beats arrive on req: op 0 executes the instruction at PC, ops 1 and 2 write
// or read a memory byte, op 3 reads a screen pixel, ops 4 and 5 set the delay
// and sound values, and ops 6 and 7 start and stop the core. Every request
// beat gives exactly one beat on rsp that shows PC, I, VF, the read byte, the
// timers and the halted and key-wait flags after the request.
// Requests are handled one at a time; req.ready is high only while the core
// is idle and no response is pending, so the next request is taken in the
// cycle after the response beat at the earliest. An instruction's response
// beat follows the two byte-wide memory fetches and the register reads.
// An execute beat to a halted core goes straight to its response. A sprite
// draw reads each row byte, then visits its pixels, toggling each set one
// by a read and a write, and writes VF at the end; Fx55 writes the registers
// one by one, Fx65 reads each byte and then loads it, Fx33 writes its three
// digits in turn, and 00E0 waits for the row-by-row screen clear.
// After reset the memory is filled with the font and zeros one byte per cycle,
// so req.ready stays low until the memory is filled. A stalled rsp holds its
// beat, and no new request is taken until it has been delivered.
`default_nettype none
module chip8_instruction_core #(
  parameter int MEM_BYTES = c8_pkg::MEM_BYTES_DEF,
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF,
  parameter int PROGRAM_START = c8_pkg::PROGRAM_START_DEF
) (
  input wire logic clk,
  input wire logic rst,
  c8_req_if.sink   req,
  c8_rsp_if.source rsp
);
  localparam int AW = $clog2(MEM_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_HOST, S_HOSTD, S_F0, S_F1, S_F2, S_RX, S_RY, S_EXEC, S_CLS,
    S_DROW, S_DROWD, S_DPIX, S_DMOD, S_DNEXT, S_DEND, S_STORE, S_LOAD, S_LOADD,
    S_BCD, S_FIN
  } state_t;

  state_t state;
  logic [11:0] pc;
  logic [15:0] idx;
  logic [SPW-1:0] sp;
  logic [7:0] delay;
  logic [7:0] sound;
  logic halted;
  logic key_wait;
  logic [15:0] prev_keys;
  logic [7:0] regs [16];
  logic [11:0] stack [STACK_DEPTH];

  c8_pkg::op_t op_q;
  logic [11:0] addr_q;
  logic [7:0] data_q;
  logic [15:0] keys_q;
  logic [7:0] rnd_q;
  logic [7:0] hi_q;
  logic [15:0] opc;
  logic [7:0] vx_q;
  logic [7:0] vy_q;
  logic [7:0] rd_q;
  logic [3:0] cnt;
  logic [2:0] col;
  logic [7:0] row_q;
  logic [10:0] pix_q;
  logic hit;

  logic mem_ready;
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0] mem_wdata;
  logic [7:0] mem_rdata;
  logic scr_clr;
  logic scr_busy;
  logic scr_we;
  logic [c8_pkg::SCR_RW-1:0] scr_row;
  logic [c8_pkg::SCR_W-1:0] scr_wdata;
  logic [c8_pkg::SCR_W-1:0] scr_rdata;

  c8_pkg::alu_fn_t alu_fn;
  logic [7:0] alu_b;
  logic [7:0] alu_res;
  logic alu_flag;

  logic [3:0] x;
  logic [3:0] n;
  logic [7:0] kk;
  logic [11:0] nnn;
  logic [11:0] pc_adv2;
  logic [11:0] pc_adv4;
  logic [3:0] reg_sel;
  logic [7:0] reg_rd;
  logic [SPW-1:0] sp_inc;
  logic [SPW-1:0] sp_dec;
  logic [16:0] idx_sum;
  logic [16:0] idx_vx;
  logic [16:0] pc_next_byte;
  logic [10:0] pix;
  logic [7:0] bcd_h;
  logic [7:0] bcd_r;
  logic [15:0] bcd_m;
  logic [7:0] bcd_t;
  logic [7:0] bcd_o;
  logic [7:0] bcd_digit;
  logic [15:0] new_keys;
  logic key_found;
  logic [3:0] key_num;
  logic alu_valid;

  c8_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk(clk), .rst(rst), .ready(mem_ready), .we(mem_we), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  c8_screen u_screen (
    .clk(clk), .rst(rst), .clr(scr_clr), .busy(scr_busy), .we(scr_we), .row(scr_row),
    .wdata(scr_wdata), .rdata(scr_rdata)
  );

  c8_alu u_alu (.fn(alu_fn), .a(vx_q), .b(alu_b), .res(alu_res), .flag(alu_flag));

  assign x = opc[11:8];
  assign n = opc[3:0];
  assign kk = opc[7:0];
  assign nnn = opc[11:0];
  assign pc_adv2 = pc + 12'd2;
  assign pc_adv4 = pc + 12'd4;
  assign sp_inc = (sp == SPW'(STACK_DEPTH - 1)) ? '0 : sp + SPW'(1);
  assign sp_dec = (sp == '0) ? SPW'(STACK_DEPTH - 1) : sp - SPW'(1);
  assign idx_sum = {1'b0, idx} + {13'd0, cnt};
  assign idx_vx = {1'b0, idx} + {9'd0, vx_q};
  assign pc_next_byte = {5'd0, pc} + 17'd1;
  assign pix = {(vy_q[4:0] + {1'b0, cnt}), 6'd0} + {3'd0, vx_q} + {8'd0, col};
  assign reg_rd = regs[reg_sel];

  // Decimal digits: hundreds by compare, tens by reciprocal multiply.
  always_comb begin
    bcd_h = 8'd0;
    if (vx_q >= 8'd200) begin
      bcd_h = 8'd2;
    end else if (vx_q >= 8'd100) begin
      bcd_h = 8'd1;
    end
    bcd_r = vx_q - 8'(bcd_h * 8'd100);
    bcd_m = {8'd0, bcd_r} * 16'd205;
    bcd_t = {3'd0, bcd_m[15:11]};
    bcd_o = bcd_r - 8'(bcd_t * 8'd10);
    unique case (cnt[1:0])
      2'd0: bcd_digit = bcd_h;
      2'd1: bcd_digit = bcd_t;
      default: bcd_digit = bcd_o;
    endcase
  end

  always_comb begin
    new_keys = keys_q & ~prev_keys;
    key_found = |new_keys;
    key_num = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (new_keys[i]) begin
        key_num = 4'(i);
      end
    end
  end

  always_comb begin
    alu_b = vy_q;
    alu_fn = c8_pkg::ALU_MOV;
    alu_valid = 1'b1;
    if (opc[15:12] == 4'h7) begin
      alu_b = kk;
      alu_fn = c8_pkg::ALU_ADD;
    end else begin
      unique case (n)
        4'h0: alu_fn = c8_pkg::ALU_MOV;
        4'h1: alu_fn = c8_pkg::ALU_OR;
        4'h2: alu_fn = c8_pkg::ALU_AND;
        4'h3: alu_fn = c8_pkg::ALU_XOR;
        4'h4: alu_fn = c8_pkg::ALU_ADD;
        4'h5: alu_fn = c8_pkg::ALU_SUB;
        4'h6: alu_fn = c8_pkg::ALU_SHR;
        4'h7: alu_fn = c8_pkg::ALU_SUBN;
        4'hE: alu_fn = c8_pkg::ALU_SHL;
        default: alu_valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    reg_sel = cnt;
    if (state == S_RX) begin
      reg_sel = x;
    end else if (state == S_RY) begin
      reg_sel = opc[7:4];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_addr = idx_sum[AW-1:0];
    mem_wdata = data_q;
    unique case (state)
      S_HOST: begin
        mem_addr = AW'(addr_q);
        mem_we = (op_q == c8_pkg::OP_WRMEM);
      end
      S_F0: mem_addr = AW'(pc);
      S_F1: mem_addr = pc_next_byte[AW-1:0];
      S_STORE: begin
        mem_we = 1'b1;
        mem_wdata = reg_rd;
      end
      S_BCD: begin
        mem_we = 1'b1;
        mem_wdata = bcd_digit;
      end
      default: mem_addr = idx_sum[AW-1:0];
    endcase
  end

  always_comb begin
    scr_clr = (state == S_EXEC) && (opc == c8_pkg::OPC_CLS);
    scr_we = 1'b0;
    scr_row = pix_q[10:6];
    scr_wdata = scr_rdata;
    scr_wdata[pix_q[5:0]] = ~scr_rdata[pix_q[5:0]];
    unique case (state)
      S_HOST: scr_row = addr_q[10:6];
      S_DPIX: scr_row = pix[10:6];
      S_DMOD: scr_we = 1'b1;
      default: scr_row = pix_q[10:6];
    endcase
  end

  assign req.ready = (state == S_IDLE) && !rsp.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      pc <= 12'(PROGRAM_START);
      idx <= '0;
      sp <= '0;
      delay <= '0;
      sound <= '0;
      halted <= 1'b1;
      key_wait <= 1'b0;
      prev_keys <= '0;
      for (int i = 0; i < 16; i++) begin
        regs[i] <= '0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack[i] <= '0;
      end
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (mem_ready && !scr_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op_q <= c8_pkg::op_t'(req.op);
            addr_q <= req.addr;
            data_q <= req.data;
            keys_q <= req.keys_held;
            rnd_q <= req.random_byte;
            rd_q <= '0;
            if (c8_pkg::op_t'(req.op) == c8_pkg::OP_EXEC) begin
              state <= halted ? S_FIN : S_F0;
            end else begin
              state <= S_HOST;
            end
          end
        end
        S_HOST: state <= S_HOSTD;
        S_HOSTD: begin
          unique case (op_q)
            c8_pkg::OP_RDMEM: rd_q <= mem_rdata;
            c8_pkg::OP_RDPIX: rd_q <= {7'd0, scr_rdata[addr_q[5:0]]};
            c8_pkg::OP_SETDLY: delay <= data_q;
            c8_pkg::OP_SETSND: sound <= data_q;
            c8_pkg::OP_START: halted <= 1'b0;
            c8_pkg::OP_STOP: halted <= 1'b1;
            default: rd_q <= '0;
          endcase
          state <= S_FIN;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          hi_q <= mem_rdata;
          state <= S_F2;
        end
        S_F2: begin
          opc <= {hi_q, mem_rdata};
          state <= S_RX;
        end
        S_RX: begin
          vx_q <= reg_rd;
          state <= S_RY;
        end
        S_RY: begin
          vy_q <= reg_rd;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FIN;
          cnt <= '0;
          unique case (opc[15:12])
            4'h0: begin
              if (opc == c8_pkg::OPC_CLS) begin
                pc <= pc_adv2;
                state <= S_CLS;
              end else if (opc == c8_pkg::OPC_RET) begin
                sp <= sp_dec;
                pc <= stack[sp_dec] + 12'd2;
              end else begin
                halted <= 1'b1;
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              stack[sp] <= pc;
              sp <= sp_inc;
              pc <= nnn;
            end
            4'h3: pc <= (vx_q == kk) ? pc_adv4 : pc_adv2;
            4'h4: pc <= (vx_q != kk) ? pc_adv4 : pc_adv2;
            4'h5: pc <= (vx_q == vy_q) ? pc_adv4 : pc_adv2;
            4'h6: begin
              regs[x] <= kk;
              pc <= pc_adv2;
            end
            4'h7: begin
              regs[x] <= alu_res;
              pc <= pc_adv2;
            end
            4'h8: begin
              if (alu_valid) begin
                regs[x] <= alu_res;
                if (n >= 4'h4) begin
                  regs[15] <= {7'd0, alu_flag};
                end
                pc <= pc_adv2;
              end else begin
                halted <= 1'b1;
              end
            end
            4'h9: pc <= (vx_q != vy_q) ? pc_adv4 : pc_adv2;
            4'hA: begin
              idx <= {4'd0, nnn};
              pc <= pc_adv2;
            end
            4'hB: pc <= nnn + {4'd0, regs[0]};
            4'hC: begin
              regs[x] <= rnd_q & kk;
              pc <= pc_adv2;
            end
            4'hD: begin
              hit <= 1'b0;
              state <= (n == 4'd0) ? S_DEND : S_DROW;
            end
            4'hE: begin
              if (kk == c8_pkg::KK_SKP) begin
                pc <= keys_q[vx_q[3:0]] ? pc_adv4 : pc_adv2;
              end else if (kk == c8_pkg::KK_SKNP) begin
                pc <= keys_q[vx_q[3:0]] ? pc_adv2 : pc_adv4;
              end else begin
                halted <= 1'b1;
              end
            end
            default: begin
              unique case (kk)
                c8_pkg::KK_LDDT: begin
                  regs[x] <= delay;
                  pc <= pc_adv2;
                end
                c8_pkg::KK_WAITK: begin
                  prev_keys <= keys_q;
                  if (!key_wait) begin
                    key_wait <= 1'b1;
                  end else if (key_found) begin
                    key_wait <= 1'b0;
                    regs[x] <= {4'd0, key_num};
                    pc <= pc_adv2;
                  end
                end
                c8_pkg::KK_SETDT: begin
                  delay <= vx_q;
                  pc <= pc_adv2;
                end
                c8_pkg::KK_SETST: begin
                  sound <= vx_q;
                  pc <= pc_adv2;
                end
                c8_pkg::KK_ADDI: begin
                  regs[15] <= {7'd0, (idx_vx > 17'h00FFF)};
                  idx <= idx_vx[15:0];
                  pc <= pc_adv2;
                end
                c8_pkg::KK_FONT: begin
                  idx <= {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
                  pc <= pc_adv2;
                end
                c8_pkg::KK_BCD: state <= S_BCD;
                c8_pkg::KK_STORE: state <= S_STORE;
                c8_pkg::KK_LOAD: state <= S_LOAD;
                default: halted <= 1'b1;
              endcase
            end
          endcase
        end
        S_CLS: begin
          if (!scr_busy) begin
            state <= S_FIN;
          end
        end
        S_DROW: state <= S_DROWD;
        S_DROWD: begin
          row_q <= mem_rdata;
          col <= '0;
          state <= S_DPIX;
        end
        S_DPIX: begin
          pix_q <= pix;
          state <= row_q[3'd7 - col] ? S_DMOD : S_DNEXT;
        end
        S_DMOD: begin
          hit <= hit | scr_rdata[pix_q[5:0]];
          state <= S_DNEXT;
        end
        S_DNEXT: begin
          col <= col + 3'd1;
          state <= S_DPIX;
          if (col == 3'd7) begin
            cnt <= cnt + 4'd1;
            state <= (cnt == n - 4'd1) ? S_DEND : S_DROW;
          end
        end
        S_DEND: begin
          regs[15] <= {7'd0, hit};
          pc <= pc_adv2;
          state <= S_FIN;
        end
        S_STORE: begin
          cnt <= cnt + 4'd1;
          if (cnt == x) begin
            idx <= idx + {12'd0, x} + 16'd1;
            pc <= pc_adv2;
            state <= S_FIN;
          end
        end
        S_LOAD: state <= S_LOADD;
        S_LOADD: begin
          regs[cnt] <= mem_rdata;
          cnt <= cnt + 4'd1;
          state <= S_LOAD;
          if (cnt == x) begin
            idx <= idx + {12'd0, x} + 16'd1;
            pc <= pc_adv2;
            state <= S_FIN;
          end
        end
        S_BCD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) begin
            pc <= pc_adv2;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          rsp.valid <= 1'b1;
          rsp.pc_out <= pc;
          rsp.index_out <= idx;
          rsp.flag_out <= regs[15];
          rsp.read_data <= rd_q;
          rsp.delay_out <= delay;
          rsp.sound_out <= sound;
          rsp.stopped <= halted;
          rsp.waiting_key <= key_wait;
          state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/c8_checker.sv @@
`default_nettype none
module c8_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [11:0] rsp_pc_out
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc_out))
    else $error("Stalled response beat changed.");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid)
    else $error("Request taken while a response was pending.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Core ready right after taking a request.");

  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |=> !rsp_valid)
    else $error("Second response without a request.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("Activity right after reset.");
endmodule

bind chip8_instruction_core c8_checker u_c8_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_pc_out(rsp.pc_out)
);
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [11:0] pc_out;
    logic [15:0] index_out;
    logic [7:0]  flag_out;
    logic [7:0]  read_data;
    logic [7:0]  delay_out;
    logic [7:0]  sound_out;
    logic        stopped;
    logic        waiting_key;
  } core_view_t;

  typedef struct {
    c8_pkg::op_t op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic        has_known;
    core_view_t  known;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  c8_req_if req ();
  c8_rsp_if rsp ();

  chip8_instruction_core DUT (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  sm_mem [4096];
  logic        sm_pix [2048];
  logic [7:0]  sm_v [16];
  logic [11:0] sm_stack [16];
  logic [3:0]  sm_sp;
  logic [11:0] sm_pc;
  logic [15:0] sm_i;
  logic [7:0]  sm_dt, sm_st;
  logic        sm_halt, sm_wait;
  logic [15:0] sm_prev;

  core_view_t views_due [$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  function automatic void core_reset();
    foreach (sm_mem[k]) sm_mem[k] = (k < c8_pkg::FONT_LEN) ? c8_pkg::FONT[k] : 8'h00;
    foreach (sm_pix[k]) sm_pix[k] = 1'b0;
    foreach (sm_v[k]) sm_v[k] = 8'h00;
    foreach (sm_stack[k]) sm_stack[k] = 12'h000;
    sm_sp = 0; sm_pc = 12'h200; sm_i = 0; sm_dt = 0; sm_st = 0;
    sm_halt = 1'b1; sm_wait = 1'b0; sm_prev = 0;
  endfunction

  function automatic void run_instruction(logic [15:0] keys, logic [7:0] rnd);
    logic [15:0] opc;
    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy, res, row;
    logic [11:0] nnn;
    logic [8:0] wide;
    logic flag, hit;
    int p;
    opc = {sm_mem[sm_pc], sm_mem[sm_pc + 12'd1]};
    x = opc[11:8]; y = opc[7:4]; n = opc[3:0]; kk = opc[7:0]; nnn = opc[11:0];
    vx = sm_v[x]; vy = sm_v[y];
    case (opc[15:12])
      4'h0: begin
        if (opc == c8_pkg::OPC_CLS) begin
          foreach (sm_pix[k]) sm_pix[k] = 1'b0;
          sm_pc += 2;
        end else if (opc == c8_pkg::OPC_RET) begin
          sm_sp -= 1;
          sm_pc = sm_stack[sm_sp] + 12'd2;
        end else sm_halt = 1'b1;
      end
      4'h1: sm_pc = nnn;
      4'h2: begin
        sm_stack[sm_sp] = sm_pc;
        sm_sp += 1;
        sm_pc = nnn;
      end
      4'h3: sm_pc += (vx == kk) ? 4 : 2;
      4'h4: sm_pc += (vx != kk) ? 4 : 2;
      4'h5: sm_pc += (vx == vy) ? 4 : 2;
      4'h6: begin sm_v[x] = kk; sm_pc += 2; end
      4'h7: begin sm_v[x] = vx + kk; sm_pc += 2; end
      4'h8: begin
        flag = 1'b0;
        case (n)
          4'h0: res = vy;
          4'h1: res = vx | vy;
          4'h2: res = vx & vy;
          4'h3: res = vx ^ vy;
          4'h4: begin wide = vx + vy; res = wide[7:0]; flag = wide[8]; end
          4'h5: begin res = vx - vy; flag = vx >= vy; end
          4'h6: begin res = vx >> 1; flag = vx[0]; end
          4'h7: begin res = vy - vx; flag = vy >= vx; end
          4'hE: begin res = vx << 1; flag = vx[7]; end
          default: begin sm_halt = 1'b1; return; end
        endcase
        sm_v[x] = res;
        if (n >= 4) sm_v[15] = {7'd0, flag};
        sm_pc += 2;
      end
      4'h9: sm_pc += (vx != vy) ? 4 : 2;
      4'hA: begin sm_i = {4'd0, nnn}; sm_pc += 2; end
      4'hB: sm_pc = nnn + {4'd0, sm_v[0]};
      4'hC: begin sm_v[x] = rnd & kk; sm_pc += 2; end
      4'hD: begin
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          row = sm_mem[(sm_i + r) % 4096];
          for (int c = 0; c < 8; c++)
            if (row[7 - c]) begin
              p = (vx + c + (vy + r) * 64) % 2048;
              if (sm_pix[p]) hit = 1'b1;
              sm_pix[p] = !sm_pix[p];
            end
        end
        sm_v[15] = {7'd0, hit};
        sm_pc += 2;
      end
      4'hE: begin
        if (kk == c8_pkg::KK_SKP) sm_pc += keys[vx[3:0]] ? 4 : 2;
        else if (kk == c8_pkg::KK_SKNP) sm_pc += keys[vx[3:0]] ? 2 : 4;
        else sm_halt = 1'b1;
      end
      default: begin
        case (kk)
          c8_pkg::KK_LDDT: sm_v[x] = sm_dt;
          c8_pkg::KK_WAITK: begin
            if (!sm_wait) begin
              sm_wait = 1'b1;
              sm_prev = keys;
              return;
            end
            for (int k = 0; k < 16; k++)
              if (!sm_prev[k] && keys[k]) begin
                sm_wait = 1'b0;
                sm_v[x] = 8'(k);
                sm_prev = keys;
                sm_pc += 2;
                return;
              end
            sm_prev = keys;
            return;
          end
          c8_pkg::KK_SETDT: sm_dt = vx;
          c8_pkg::KK_SETST: sm_st = vx;
          c8_pkg::KK_ADDI: begin
            sm_v[15] = (sm_i + vx > 32'hFFF) ? 8'd1 : 8'd0;
            sm_i = sm_i + {8'd0, vx};
          end
          c8_pkg::KK_FONT: sm_i = {8'd0, vx} * 16'd5;
          c8_pkg::KK_BCD: begin
            sm_mem[sm_i % 4096] = vx / 8'd100;
            sm_mem[(sm_i + 1) % 4096] = (vx / 8'd10) % 8'd10;
            sm_mem[(sm_i + 2) % 4096] = vx % 8'd10;
          end
          c8_pkg::KK_STORE: begin
            for (int k = 0; k <= x; k++) sm_mem[(sm_i + k) % 4096] = sm_v[k];
            sm_i = sm_i + {12'd0, x} + 16'd1;
          end
          c8_pkg::KK_LOAD: begin
            for (int k = 0; k <= x; k++) sm_v[k] = sm_mem[(sm_i + k) % 4096];
            sm_i = sm_i + {12'd0, x} + 16'd1;
          end
          default: begin sm_halt = 1'b1; return; end
        endcase
        sm_pc += 2;
      end
    endcase
  endfunction

  function automatic core_view_t apply_beat(stim_row_t s);
    core_view_t v;
    logic [7:0] rd;
    rd = 0;
    case (s.op)
      c8_pkg::OP_EXEC:   if (!sm_halt) run_instruction(s.keys, s.rnd);
      c8_pkg::OP_WRMEM:  sm_mem[s.addr] = s.data;
      c8_pkg::OP_RDMEM:  rd = sm_mem[s.addr];
      c8_pkg::OP_RDPIX:  rd = {7'd0, sm_pix[s.addr[10:0]]};
      c8_pkg::OP_SETDLY: sm_dt = s.data;
      c8_pkg::OP_SETSND: sm_st = s.data;
      c8_pkg::OP_START:  sm_halt = 1'b0;
      default:           sm_halt = 1'b1;
    endcase
    v = '{sm_pc, sm_i, sm_v[15], rd, sm_dt, sm_st, sm_halt, sm_wait};
    return v;
  endfunction

  task automatic send_beat(stim_row_t s);
    core_view_t v;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= s.op; req.addr <= s.addr; req.data <= s.data;
    req.keys_held <= s.keys; req.random_byte <= s.rnd;
    do @(posedge clk); while (!req.ready);
    v = apply_beat(s);
    if (s.has_known && v != s.known) begin
      $error("table row disagrees with predictor: exp %h got %h", s.known, v);
      errors++;
    end
    views_due.push_back(v);
  endtask

  function automatic stim_row_t mk(c8_pkg::op_t op, logic [11:0] a, logic [7:0] d,
                                   logic [15:0] k = 0, logic [7:0] r = 0);
    stim_row_t s;
    s = '{op, a, d, k, r, 1'b0, '0};
    return s;
  endfunction

  task automatic put_word(logic [11:0] a, logic [15:0] w);
    send_beat(mk(c8_pkg::OP_WRMEM, a, w[15:8]));
    send_beat(mk(c8_pkg::OP_WRMEM, a + 12'd1, w[7:0]));
  endtask

  function automatic logic [15:0] rand_opcode();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 11))
      0: w = (w[0]) ? c8_pkg::OPC_CLS : c8_pkg::OPC_RET;
      1: w[15:12] = 4'h8;
      2: w = {4'h8, w[11:4], 4'hE};
      3: w = {4'hE, w[11:8], (w[0] ? c8_pkg::KK_SKP : c8_pkg::KK_SKNP)};
      4: begin
        w[15:12] = 4'hF;
        case ($urandom_range(0, 10))
          0: w[7:0] = c8_pkg::KK_LDDT;  1: w[7:0] = c8_pkg::KK_WAITK;
          2: w[7:0] = c8_pkg::KK_SETDT; 3: w[7:0] = c8_pkg::KK_SETST;
          4: w[7:0] = c8_pkg::KK_ADDI;  5: w[7:0] = c8_pkg::KK_FONT;
          6: w[7:0] = c8_pkg::KK_BCD;   7: w[7:0] = c8_pkg::KK_STORE;
          8: w[7:0] = c8_pkg::KK_LOAD;
          default: ;
        endcase
      end
      5: w = {4'hD, w[11:4], 4'($urandom_range(0, 6))};
      6: w = {4'hA, 2'b00, w[9:0]};
      default: ;
    endcase
    if (w[15:12] == 4'hD && $urandom_range(0, 9) != 0) w[3:0] = 4'($urandom_range(0, 4));
    return w;
  endfunction

  task automatic random_program();
    logic [11:0] base;
    int len;
    base = $urandom_range(0, 1) ? 12'h200 + 12'($urandom_range(0, 60) * 2) : 12'($urandom);
    len = $urandom_range(2, 8);
    for (int k = 0; k < len; k++) put_word(base + 12'(2 * k), rand_opcode());
    for (int k = 0; k < 3; k++) begin
      send_beat(mk(c8_pkg::OP_EXEC, 0, 0, 16'h0000, 8'($urandom)));
      send_beat(mk(c8_pkg::OP_RDMEM, sm_pc, 0));
    end
  endtask

  initial begin
    stim_row_t dir_rows [$];
    stim_row_t s;
    req.valid = 1'b0; req.op = c8_pkg::OP_EXEC; req.addr = 0; req.data = 0;
    req.keys_held = 0; req.random_byte = 0;
    core_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    s = mk(c8_pkg::OP_RDMEM, 12'd0, 0);
    s.has_known = 1; s.known = '{12'h200, 0, 0, 8'hF0, 0, 0, 1'b1, 1'b0};
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_EXEC, 0, 0);
    s.has_known = 1; s.known = '{12'h200, 0, 0, 0, 0, 0, 1'b1, 1'b0};
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_SETDLY, 12'hFFF, 8'hFF);
    s.has_known = 1; s.known = '{12'h200, 0, 0, 0, 8'hFF, 0, 1'b1, 1'b0};
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_SETSND, 0, 8'hFF);
    s.has_known = 1; s.known = '{12'h200, 0, 0, 0, 8'hFF, 8'hFF, 1'b1, 1'b0};
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_RDPIX, 12'hFFF, 0, 16'hFFFF, 8'hFF);
    s.has_known = 1; s.known = '{12'h200, 0, 0, 0, 8'hFF, 8'hFF, 1'b1, 1'b0};
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_WRMEM, 12'hFFF, 8'hAB);
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_RDMEM, 12'hFFF, 0);
    s.has_known = 1; s.known = '{12'h200, 0, 0, 8'hAB, 8'hFF, 8'hFF, 1'b1, 1'b0};
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_START, 0, 0);
    dir_rows.push_back(s);
    s = mk(c8_pkg::OP_STOP, 0, 0);
    dir_rows.push_back(s);
    foreach (dir_rows[k]) send_beat(dir_rows[k]);

    // A short program covering carry, borrow, VF as destination, draw with wrap,
    // BCD, store and load, key skips, key wait, call and return.
    begin
      logic [15:0] prog [] = '{16'h60FF, 16'h6F01, 16'h8F04, 16'h61FF, 16'h8104,
        16'h8015, 16'h8F06, 16'h80EE, 16'h5011, 16'h6A3F, 16'h6B1F, 16'hF029,
        16'hDAB5, 16'hDAB5, 16'hF033, 16'hFF55, 16'hA000, 16'hF365, 16'hE19E,
        16'hE1A1, 16'hF50A, 16'h2300, 16'h7E01, 16'hFE1E, 16'h8008};
      foreach (prog[k]) put_word(12'h200 + 12'(2 * k), prog[k]);
      put_word(12'h300, c8_pkg::OPC_RET);
      put_word(12'hFFE, 16'h1200);
      send_beat(mk(c8_pkg::OP_START, 0, 0));
      for (int k = 0; k < 30; k++)
        send_beat(mk(c8_pkg::OP_EXEC, 0, 0, (k >= 22) ? 16'h8001 : 16'h0001, 8'hFF));
    end

    for (int k = 0; k < 115; k++) begin
      if (k == 60) long_hold = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        s = mk(c8_pkg::op_t'($urandom_range(0, 7)), 12'($urandom), 8'($urandom),
               16'($urandom), 8'($urandom));
        send_beat(s);
      end else begin
        if (sm_halt) send_beat(mk(c8_pkg::OP_START, 0, 0));
        random_program();
      end
      if (sm_wait)
        repeat (3) send_beat(mk(c8_pkg::OP_EXEC, 0, 0, 16'($urandom), 8'($urandom)));
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    core_view_t e;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      if (rsp.valid && rsp.ready) begin
        if (views_due.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          e = views_due.pop_front();
          if (rsp.pc_out !== e.pc_out) begin
            $error("pc_out exp %h got %h", e.pc_out, rsp.pc_out); errors++;
          end
          if (rsp.index_out !== e.index_out) begin
            $error("index_out exp %h got %h", e.index_out, rsp.index_out); errors++;
          end
          if (rsp.flag_out !== e.flag_out) begin
            $error("flag_out exp %h got %h", e.flag_out, rsp.flag_out); errors++;
          end
          if (rsp.read_data !== e.read_data) begin
            $error("read_data exp %h got %h", e.read_data, rsp.read_data); errors++;
          end
          if (rsp.delay_out !== e.delay_out) begin
            $error("delay_out exp %h got %h", e.delay_out, rsp.delay_out); errors++;
          end
          if (rsp.sound_out !== e.sound_out) begin
            $error("sound_out exp %h got %h", e.sound_out, rsp.sound_out); errors++;
          end
          if (rsp.stopped !== e.stopped) begin
            $error("stopped exp %b got %b", e.stopped, rsp.stopped); errors++;
          end
          if (rsp.waiting_key !== e.waiting_key) begin
            $error("waiting_key exp %b got %b", e.waiting_key, rsp.waiting_key); errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 12) == 0);
    end
  end

  initial begin
    wait (stim_done && views_due.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && views_due.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
